// ----- src/esp_pkg.sv -----
// Shared types and constants of the encoder servo position loop.
package esp_pkg;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_POS_GAIN      = 3'd0;
    localparam logic [2:0] REG_INT_GAIN      = 3'd1;
    localparam logic [2:0] REG_VEL_INT_GAIN  = 3'd2;
    localparam logic [2:0] REG_DAMP_GAIN     = 3'd3;
    localparam logic [2:0] REG_RATED_CURRENT = 3'd4;
    localparam logic [2:0] REG_HOME_OFFSET   = 3'd5;

    // Action codes
    localparam logic [1:0] ACT_POSITION = 2'd0;
    localparam logic [1:0] ACT_CURRENT  = 2'd1;

    // Lead angle curve
    localparam logic signed [47:0] LEAD_BP0  = 48'sd100000;
    localparam logic signed [47:0] LEAD_BP1  = 48'sd1300000;
    localparam logic signed [47:0] LEAD_BP2  = 48'sd2200000;
    localparam logic signed [47:0] LEAD_K0   = 48'sd262;
    localparam logic signed [47:0] LEAD_K1   = 48'sd105;
    localparam logic signed [47:0] LEAD_K2   = 48'sd52;
    localparam logic signed [47:0] LEAD_OFS1 = 48'sd300;
    localparam logic signed [47:0] LEAD_OFS2 = 48'sd390;
    localparam logic signed [47:0] LEAD_MAX  = 48'sd430;

    // Error clamps
    localparam logic signed [32:0] PERR_MAX = 33'sd3200;
    localparam logic signed [32:0] VERR_MAX = 33'sd4000;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_SEED,
        OP_UNWRAP,
        OP_LEAD,
        OP_ERR,
        OP_MAC_IG,
        OP_MAC_VG,
        OP_INTEG,
        OP_MAC_PG,
        OP_MAC_DG,
        OP_DRV_PID,
        OP_DRV_CUR,
        OP_DRV_OFF,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic       seeded;
        logic [1:0] act;
        logic       out_free;
    } dp_status_t;

endpackage

// ----- src/esp_datapath.sv -----
// Datapath: configuration, loop state, shared gain multiplier and output register.
module esp_datapath #(
    parameter int STEPS_PER_REV = 51200,
    parameter int TICK_RATE     = 20000,
    parameter int QUARTER_PHASE = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wen,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic [95:0]         s_tdata,
    input  logic [1:0]          s_tuser,
    input  esp_pkg::dp_cmd_t    cmd,
    output esp_pkg::dp_status_t status,
    input  logic                m_tready,
    output logic                m_tvalid,
    output logic [111:0]        m_tdata
);

    localparam logic signed [18:0] STEPS_S  = 19'(STEPS_PER_REV);
    localparam logic signed [18:0] HALF_DN  = 19'(STEPS_PER_REV / 2);
    localparam logic signed [18:0] HALF_UP  = 19'((STEPS_PER_REV + 1) / 2);
    localparam logic [31:0]        TICK_K   = 32'(TICK_RATE);
    localparam logic [31:0]        QPHASE   = 32'(QUARTER_PHASE);

    logic [15:0] pos_gain_reg, int_gain_reg, vel_int_gain_reg, damp_gain_reg;
    logic [14:0] rated_reg;
    logic [15:0] home_reg;

    logic [15:0]        lap_reg;
    logic signed [31:0] tpos_reg, tvel_reg;
    logic signed [15:0] tcur_reg;
    logic [1:0]         act_reg;

    logic               seeded_reg;
    logic [15:0]        last_lap_reg;
    logic [31:0]        run_pos_reg, vel_accum_reg, vel_est_reg, int_frac_reg, int_term_reg;
    logic [31:0]        drv_ang_reg;
    logic signed [15:0] drv_cur_reg;
    logic [31:0]        est_pos_reg;
    logic signed [12:0] perr_reg, verr_reg;
    logic signed [33:0] acc_reg;
    logic               m_valid_reg;
    logic [111:0]       m_data_reg;

    // Configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_gain_reg     <= '0;
            int_gain_reg     <= '0;
            vel_int_gain_reg <= '0;
            damp_gain_reg    <= '0;
            rated_reg        <= 15'd1000;
            home_reg         <= '0;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                esp_pkg::REG_POS_GAIN:      pos_gain_reg     <= cfg_data;
                esp_pkg::REG_INT_GAIN:      int_gain_reg     <= cfg_data;
                esp_pkg::REG_VEL_INT_GAIN:  vel_int_gain_reg <= cfg_data;
                esp_pkg::REG_DAMP_GAIN:     damp_gain_reg    <= cfg_data;
                esp_pkg::REG_RATED_CURRENT: rated_reg        <= cfg_data[14:0];
                esp_pkg::REG_HOME_OFFSET:   home_reg         <= cfg_data;
                default: ;
            endcase
        end
    end

    // Seeding angle
    logic signed [18:0] lap_s, home_s, seed_angle;
    always_comb
    begin
        lap_s      = 19'($unsigned(lap_reg));
        home_s     = 19'($unsigned(home_reg));
        seed_angle = lap_s;
        if (home_s < HALF_DN)
        begin
            if (lap_s > home_s + HALF_DN)
                seed_angle = lap_s - STEPS_S;
        end
        else if (lap_s < home_s - HALF_DN)
        begin
            seed_angle = lap_s + STEPS_S;
        end
    end

    // Lap unwrap and velocity filter
    logic signed [18:0] delta;
    logic [31:0]        delta32, vsum;
    always_comb
    begin
        delta = lap_s - 19'($unsigned(last_lap_reg));
        if (delta > HALF_DN)
            delta = delta - STEPS_S;
        else if (delta < -HALF_UP)
            delta = delta + STEPS_S;
        delta32 = 32'(delta);
        vsum    = vel_accum_reg + delta32 * TICK_K + (vel_est_reg << 5) - vel_est_reg;
    end

    // Lead angle from the velocity estimate
    logic signed [47:0] vx, lead;
    always_comb
    begin
        vx = 48'($signed(vel_est_reg));
        if (vx < 0)
        begin
            if (vx > -esp_pkg::LEAD_BP0)
                lead = '0;
            else if (vx > -esp_pkg::LEAD_BP1)
                lead = ((vx + esp_pkg::LEAD_BP0) * esp_pkg::LEAD_K0) >>> 20;
            else if (vx > -esp_pkg::LEAD_BP2)
                lead = (((vx + esp_pkg::LEAD_BP1) * esp_pkg::LEAD_K1) >>> 20)
                       - esp_pkg::LEAD_OFS1;
            else
                lead = (((vx + esp_pkg::LEAD_BP2) * esp_pkg::LEAD_K2) >>> 20)
                       - esp_pkg::LEAD_OFS2;
            if (lead < -esp_pkg::LEAD_MAX)
                lead = -esp_pkg::LEAD_MAX;
        end
        else
        begin
            if (vx < esp_pkg::LEAD_BP0)
                lead = '0;
            else if (vx < esp_pkg::LEAD_BP1)
                lead = ((vx - esp_pkg::LEAD_BP0) * esp_pkg::LEAD_K0) >>> 20;
            else if (vx < esp_pkg::LEAD_BP2)
                lead = (((vx - esp_pkg::LEAD_BP1) * esp_pkg::LEAD_K1) >>> 20)
                       + esp_pkg::LEAD_OFS1;
            else
                lead = (((vx - esp_pkg::LEAD_BP2) * esp_pkg::LEAD_K2) >>> 20)
                       + esp_pkg::LEAD_OFS2;
            if (lead > esp_pkg::LEAD_MAX)
                lead = esp_pkg::LEAD_MAX;
        end
    end

    // Clamped errors
    logic signed [32:0] pdiff, vdiff;
    logic signed [12:0] perr_c, verr_c;
    always_comb
    begin
        pdiff = 33'(tpos_reg) - 33'($signed(est_pos_reg));
        vdiff = (33'(tvel_reg) - 33'($signed(vel_est_reg))) >>> 7;
        if (pdiff > esp_pkg::PERR_MAX)
            perr_c = 13'(esp_pkg::PERR_MAX);
        else if (pdiff < -esp_pkg::PERR_MAX)
            perr_c = 13'(-esp_pkg::PERR_MAX);
        else
            perr_c = 13'(pdiff);
        if (vdiff > esp_pkg::VERR_MAX)
            verr_c = 13'(esp_pkg::VERR_MAX);
        else if (vdiff < -esp_pkg::VERR_MAX)
            verr_c = 13'(-esp_pkg::VERR_MAX);
        else
            verr_c = 13'(vdiff);
    end

    // Shared gain multiplier
    logic [15:0]        mul_gain;
    logic signed [12:0] mul_err;
    logic signed [29:0] mul_a, mul_b, prod;
    always_comb
    begin
        case (cmd.op)
            esp_pkg::OP_MAC_IG: begin mul_gain = int_gain_reg;     mul_err = perr_reg; end
            esp_pkg::OP_MAC_VG: begin mul_gain = vel_int_gain_reg; mul_err = verr_reg; end
            esp_pkg::OP_MAC_PG: begin mul_gain = pos_gain_reg;     mul_err = perr_reg; end
            default:            begin mul_gain = damp_gain_reg;    mul_err = verr_reg; end
        endcase
        mul_a = 30'($signed({1'b0, mul_gain}));
        mul_b = 30'(mul_err);
        prod  = mul_a * mul_b;
    end

    // Integral carry and clamps
    logic signed [33:0] carry, isum, ilim, iclamp, qcur, rlim;
    logic signed [15:0] pid_cur, dir_cur;
    always_comb
    begin
        carry = acc_reg >>> 7;
        isum  = 34'($signed(int_term_reg)) + carry;
        ilim  = 34'($unsigned(rated_reg)) <<< 10;
        rlim  = 34'($unsigned(rated_reg));
        if (isum > ilim)
            iclamp = ilim;
        else if (isum < -ilim)
            iclamp = -ilim;
        else
            iclamp = isum;
        qcur = acc_reg >>> 10;
        if (qcur > rlim)
            pid_cur = 16'(rlim);
        else if (qcur < -rlim)
            pid_cur = 16'(-rlim);
        else
            pid_cur = 16'(qcur);
        if (34'(tcur_reg) > rlim)
            dir_cur = 16'(rlim);
        else if (34'(tcur_reg) < -rlim)
            dir_cur = 16'(-rlim);
        else
            dir_cur = tcur_reg;
    end

    function automatic logic [31:0] drive_angle_of(input logic [31:0] pos,
                                                   input logic signed [15:0] cur);
        logic [31:0] a;
        if (cur > 0)
            a = pos + QPHASE;
        else if (cur < 0)
            a = pos - QPHASE;
        else
            a = pos;
        return a;
    endfunction

    // Loop state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seeded_reg    <= 1'b0;
            last_lap_reg  <= '0;
            run_pos_reg   <= '0;
            vel_accum_reg <= '0;
            vel_est_reg   <= '0;
            int_frac_reg  <= '0;
            int_term_reg  <= '0;
            drv_ang_reg   <= '0;
            drv_cur_reg   <= '0;
        end
        else
        begin
            case (cmd.op)
                esp_pkg::OP_SEED:
                begin
                    run_pos_reg  <= 32'(seed_angle);
                    last_lap_reg <= lap_reg;
                    seeded_reg   <= 1'b1;
                end
                esp_pkg::OP_UNWRAP:
                begin
                    last_lap_reg  <= lap_reg;
                    run_pos_reg   <= run_pos_reg + delta32;
                    vel_est_reg   <= 32'($signed(vsum) >>> 5);
                    vel_accum_reg <= {27'b0, vsum[4:0]};
                end
                esp_pkg::OP_INTEG:
                begin
                    int_frac_reg <= {25'b0, acc_reg[6:0]};
                    int_term_reg <= 32'(iclamp);
                end
                esp_pkg::OP_DRV_PID:
                begin
                    drv_cur_reg <= pid_cur;
                    drv_ang_reg <= drive_angle_of(est_pos_reg, pid_cur);
                end
                esp_pkg::OP_DRV_CUR:
                begin
                    drv_cur_reg <= dir_cur;
                    drv_ang_reg <= drive_angle_of(est_pos_reg, dir_cur);
                end
                esp_pkg::OP_DRV_OFF:
                begin
                    int_frac_reg <= '0;
                    int_term_reg <= '0;
                    drv_cur_reg  <= '0;
                    drv_ang_reg  <= '0;
                end
                default: ;
            endcase
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            esp_pkg::OP_CAPTURE:
            begin
                lap_reg  <= s_tdata[15:0];
                tpos_reg <= $signed(s_tdata[47:16]);
                tvel_reg <= $signed(s_tdata[79:48]);
                tcur_reg <= $signed(s_tdata[95:80]);
                act_reg  <= s_tuser;
            end
            esp_pkg::OP_SEED:   est_pos_reg <= '0;
            esp_pkg::OP_LEAD:   est_pos_reg <= run_pos_reg + 32'(lead);
            esp_pkg::OP_ERR:
            begin
                perr_reg <= perr_c;
                verr_reg <= verr_c;
            end
            esp_pkg::OP_MAC_IG: acc_reg <= 34'($signed(int_frac_reg)) + 34'(prod);
            esp_pkg::OP_MAC_VG,
            esp_pkg::OP_MAC_PG,
            esp_pkg::OP_MAC_DG: acc_reg <= acc_reg + 34'(prod);
            esp_pkg::OP_INTEG:  acc_reg <= iclamp;
            default: ;
        endcase
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (cmd.op == esp_pkg::OP_EMIT)
            m_valid_reg <= 1'b1;
        else if (m_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == esp_pkg::OP_EMIT)
            m_data_reg <= {vel_est_reg, est_pos_reg, drv_cur_reg, drv_ang_reg};
    end

    assign m_tvalid        = m_valid_reg;
    assign m_tdata         = m_data_reg;
    assign status.seeded   = seeded_reg;
    assign status.act      = act_reg;
    assign status.out_free = !m_valid_reg || m_tready;

endmodule

// ----- src/esp_ctrl.sv -----
// Controller: sequences one control tick through the datapath.
module esp_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  esp_pkg::dp_status_t status,
    output esp_pkg::dp_cmd_t    cmd
);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_UNWRAP = 11'b00000000010,
        S_LEAD   = 11'b00000000100,
        S_ERR    = 11'b00000001000,
        S_MIG    = 11'b00000010000,
        S_MVG    = 11'b00000100000,
        S_INT    = 11'b00001000000,
        S_MPG    = 11'b00010000000,
        S_MDG    = 11'b00100000000,
        S_DRV    = 11'b01000000000,
        S_EMIT   = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = esp_pkg::OP_NONE;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.op     = esp_pkg::OP_CAPTURE;
                    state_next = S_UNWRAP;
                end
            end
            S_UNWRAP:
            begin
                if (status.seeded)
                begin
                    cmd.op     = esp_pkg::OP_UNWRAP;
                    state_next = S_LEAD;
                end
                else
                begin
                    cmd.op     = esp_pkg::OP_SEED;
                    state_next = S_EMIT;
                end
            end
            S_LEAD:
            begin
                cmd.op     = esp_pkg::OP_LEAD;
                state_next = S_ERR;
            end
            S_ERR:
            begin
                case (status.act)
                    esp_pkg::ACT_POSITION:
                    begin
                        cmd.op     = esp_pkg::OP_ERR;
                        state_next = S_MIG;
                    end
                    esp_pkg::ACT_CURRENT:
                    begin
                        cmd.op     = esp_pkg::OP_DRV_CUR;
                        state_next = S_EMIT;
                    end
                    default:
                    begin
                        cmd.op     = esp_pkg::OP_DRV_OFF;
                        state_next = S_EMIT;
                    end
                endcase
            end
            S_MIG:
            begin
                cmd.op     = esp_pkg::OP_MAC_IG;
                state_next = S_MVG;
            end
            S_MVG:
            begin
                cmd.op     = esp_pkg::OP_MAC_VG;
                state_next = S_INT;
            end
            S_INT:
            begin
                cmd.op     = esp_pkg::OP_INTEG;
                state_next = S_MPG;
            end
            S_MPG:
            begin
                cmd.op     = esp_pkg::OP_MAC_PG;
                state_next = S_MDG;
            end
            S_MDG:
            begin
                cmd.op     = esp_pkg::OP_MAC_DG;
                state_next = S_DRV;
            end
            S_DRV:
            begin
                cmd.op     = esp_pkg::OP_DRV_PID;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                // hold until the output register is free
                if (status.out_free)
                begin
                    cmd.op     = esp_pkg::OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- src/encoder_servo_position_loop.sv -----
// Top level of the encoder servo position loop.
// Usage:
//   The s_ channel takes one control tick per item: encoder lap angle, target
//   position, velocity and current in s_tdata, and the action code in s_tuser.
//   The m_ channel returns one result item per tick: drive angle, drive current,
//   estimated position and estimated velocity.
//   Gains, rated current and home offset are written on the cfg_ port while idle.
// Sequence:
//   Position mode: unwrap, lead, error, two multiply-accumulates, integral
//   update, two more multiply-accumulates, drive, emit. Current and disabled
//   modes: unwrap, lead, drive, emit; the seeding tick: seed, emit. Idle comes
//   before the next accept. One tick runs at a time, sharing one gain multiplier.
// Reset:
//   Registers take their reset values, loop state clears and the next tick only
//   seeds the running position from the lap angle, within half a turn of home.
// Stall:
//   A finished result sits in the output register while the next tick is taken;
//   a tick that finishes while the register is still full holds until it drains.
module encoder_servo_position_loop #(
    parameter int STEPS_PER_REV = 51200,
    parameter int TICK_RATE     = 20000,
    parameter int QUARTER_PHASE = 256
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wen,
    input  logic [2:0]   cfg_index,
    input  logic [15:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // lap_angle[15:0], target_position[47:16], target_velocity[79:48],
    // target_current[95:80]
    input  logic [95:0]  s_tdata,
    // action[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // drive_angle[31:0], drive_current[47:32], est_position[79:48],
    // est_velocity[111:80]
    output logic [111:0] m_tdata
);

    esp_pkg::dp_cmd_t    cmd;
    esp_pkg::dp_status_t status;

    esp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    esp_datapath #(
        .STEPS_PER_REV (STEPS_PER_REV),
        .TICK_RATE     (TICK_RATE),
        .QUARTER_PHASE (QUARTER_PHASE)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .status    (status),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

    logic signed [15:0] out_cur;
    logic [31:0]        out_ang, out_pos;
    assign out_cur = $signed(m_tdata[47:32]);
    assign out_ang = m_tdata[31:0];
    assign out_pos = m_tdata[79:48];

    a_one_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second item accepted while a tick is in progress");

    a_zero_angle: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_cur == 16'sd0) |-> (out_ang == out_pos || out_ang == 32'd0))
        else $error("zero current with a shifted drive angle");

    a_pos_angle: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_cur > 16'sd0) |-> (out_ang == out_pos + 32'(QUARTER_PHASE)))
        else $error("positive current without forward phase shift");

    a_neg_angle: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_cur < 16'sd0) |-> (out_ang == out_pos - 32'(QUARTER_PHASE)))
        else $error("negative current without backward phase shift");

endmodule
